>>> design/fdtp_pkg.sv
package fdtp_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned WordBytes = 4;
  localparam logic [WordBits-1:0] SizeLimitReset = 32'h0010_0000;

  localparam logic [WordBits-1:0] TokBeginNode = 32'h0000_0001;
  localparam logic [WordBits-1:0] TokEndNode   = 32'h0000_0002;
  localparam logic [WordBits-1:0] TokProp      = 32'h0000_0003;
  localparam logic [WordBits-1:0] TokNop       = 32'h0000_0004;
  localparam logic [WordBits-1:0] TokEnd       = 32'h0000_0009;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_NAME,
    PH_LEN,
    PH_NAMEOFF,
    PH_DATA,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [3:0] {
    K_BEGIN,
    K_ENDNODE,
    K_PROP,
    K_NOP,
    K_END,
    K_NAME,
    K_LEN,
    K_NAMEOFF,
    K_DATA,
    K_DONE,
    K_ERROR
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [WordBits-1:0] payload;
    logic [2:0]          valid_bytes;
    logic                last_word;
  } res_t;

endpackage

>>> design/fdtp_in_if.sv
interface fdtp_in_if;
  logic        valid;
  logic        ready;
  logic        restart;
  logic [31:0] word;

  modport source (output valid, output restart, output word, input ready);
  modport sink (input valid, input restart, input word, output ready);
endinterface

>>> design/fdtp_out_if.sv
interface fdtp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [31:0] payload;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (
    output valid, output kind, output payload, output valid_bytes, output last_word,
    input ready
  );
  modport sink (
    input valid, input kind, input payload, input valid_bytes, input last_word,
    output ready
  );
endinterface

>>> design/fdt_structure_token_parser.sv
// flattened device tree structure block parser
// in_i carries one big-endian structure word per transfer, with restart set on
// the first word of a tree; out_o carries one classified result per input
// word (token, name, length, name offset, data, done or error), in order.
// cfg_we_i / cfg_wdata_i write the token size limit; write it only while idle.
// a result is registered: it enters the result register, or the skid register while out_o stalls.
// throughput: one word per cycle while in_i.ready is high; the phase, offset and length update is a
// single level of logic from the state registers to the result register.
// a two-entry output buffer (result register plus skid register) lets in_i
// take a word while a result waits; when out_o stalls and both entries are
// full, in_i.ready drops until the receiver takes a result.
// reset: parser is done (only done results until a restart word), offset and
// length are zero, size limit is 1 MiB, output buffer is empty.
// an unknown token or a token at or past the limit gives a sticky error that
// only a restart clears.
module fdt_structure_token_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fdtp_pkg::WordBits-1:0] cfg_wdata_i,
  fdtp_in_if.sink                     in_i,
  fdtp_out_if.source                  out_o
);
  import fdtp_pkg::*;

  logic [WordBits-1:0] limit_q;
  phase_e              phase_q, phase_d;
  logic [WordBits-1:0] offset_q, offset_d;
  logic [WordBits-1:0] left_q, left_d;

  res_t res_d, out_q, skid_q;
  logic out_v_q, skid_v_q;

  logic                in_acc;
  logic                out_acc;
  phase_e              ph_eff;
  logic [WordBits-1:0] off_eff;
  logic [WordBits-1:0] left_eff;
  logic [WordBits:0]   off_sum;
  logic [WordBits-1:0] off_adv;
  logic [2:0]          name_cnt;
  logic                name_end;
  logic [2:0]          data_cnt;
  logic [WordBits-1:0] word;

  assign word    = in_i.word;
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_v_q && out_o.ready;

  assign ph_eff   = in_i.restart ? PH_TOKEN : phase_q;
  assign off_eff  = in_i.restart ? '0 : offset_q;
  assign left_eff = in_i.restart ? '0 : left_q;

  // saturating offset advance by one word
  assign off_sum = {1'b0, off_eff} + (WordBits+1)'(WordBytes);
  assign off_adv = off_sum[WordBits] ? '1 : off_sum[WordBits-1:0];

  // bytes before the nul
  always_comb begin
    name_end = 1'b1;
    if (word[31:24] == 8'h00) begin
      name_cnt = 3'd0;
    end else if (word[23:16] == 8'h00) begin
      name_cnt = 3'd1;
    end else if (word[15:8] == 8'h00) begin
      name_cnt = 3'd2;
    end else if (word[7:0] == 8'h00) begin
      name_cnt = 3'd3;
    end else begin
      name_cnt = 3'd4;
      name_end = 1'b0;
    end
  end

  assign data_cnt = (left_eff < WordBits'(WordBytes)) ? left_eff[2:0] : 3'(WordBytes);

  // next state
  always_comb begin
    phase_d  = ph_eff;
    offset_d = off_eff;
    left_d   = left_eff;
    case (ph_eff)
      PH_TOKEN: begin
        if (off_eff >= limit_q) begin
          phase_d = PH_ERROR;
        end else begin
          offset_d = off_adv;
          case (word)
            TokBeginNode: phase_d = PH_NAME;
            TokEndNode:   phase_d = PH_TOKEN;
            TokProp:      phase_d = PH_LEN;
            TokNop:       phase_d = PH_TOKEN;
            TokEnd:       phase_d = PH_DONE;
            default:      phase_d = PH_ERROR;
          endcase
        end
      end
      PH_NAME: begin
        offset_d = off_adv;
        if (name_end) begin
          phase_d = PH_TOKEN;
        end
      end
      PH_LEN: begin
        offset_d = off_adv;
        left_d   = word;
        phase_d  = PH_NAMEOFF;
      end
      PH_NAMEOFF: begin
        offset_d = off_adv;
        phase_d  = (left_eff == '0) ? PH_TOKEN : PH_DATA;
      end
      PH_DATA: begin
        offset_d = off_adv;
        left_d   = left_eff - WordBits'(data_cnt);
        if (left_eff == WordBits'(data_cnt)) begin
          phase_d = PH_TOKEN;
        end
      end
      PH_ERROR: phase_d = PH_ERROR;
      default:  phase_d = PH_DONE;
    endcase
  end

  // result
  always_comb begin
    res_d             = '0;
    res_d.kind        = K_DONE;
    res_d.valid_bytes = '0;
    res_d.last_word   = 1'b0;
    case (ph_eff)
      PH_TOKEN: begin
        if (off_eff >= limit_q) begin
          res_d.kind = K_ERROR;
        end else begin
          case (word)
            TokBeginNode: res_d.kind = K_BEGIN;
            TokEndNode:   res_d.kind = K_ENDNODE;
            TokProp:      res_d.kind = K_PROP;
            TokNop:       res_d.kind = K_NOP;
            TokEnd:       res_d.kind = K_END;
            default:      res_d.kind = K_ERROR;
          endcase
        end
      end
      PH_NAME: begin
        res_d.kind        = K_NAME;
        res_d.payload     = word;
        res_d.valid_bytes = name_cnt;
        res_d.last_word   = name_end;
      end
      PH_LEN: begin
        res_d.kind    = K_LEN;
        res_d.payload = word;
      end
      PH_NAMEOFF: begin
        res_d.kind    = K_NAMEOFF;
        res_d.payload = word;
      end
      PH_DATA: begin
        res_d.kind        = K_DATA;
        res_d.payload     = word;
        res_d.valid_bytes = data_cnt;
        res_d.last_word   = (left_eff == WordBits'(data_cnt));
      end
      PH_ERROR: res_d.kind = K_ERROR;
      default:  res_d.kind = K_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= SizeLimitReset;
      phase_q  <= PH_DONE;
      offset_q <= '0;
      left_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        phase_q  <= phase_d;
        offset_q <= offset_d;
        left_q   <= left_d;
      end
    end
  end

  // result register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_acc || !out_v_q) begin
        out_v_q  <= skid_v_q || in_acc;
        skid_v_q <= 1'b0;
      end else if (in_acc) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  assign in_i.ready        = !skid_v_q;
  assign out_o.valid       = out_v_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.payload     = out_q.payload;
  assign out_o.valid_bytes = out_q.valid_bytes;
  assign out_o.last_word   = out_q.last_word;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds a result while the output register is empty");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ERROR && !(in_acc && in_i.restart)) |=> phase_q == PH_ERROR)
    else $error("error phase left without a restart");

  a_side_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_o.kind != K_NAME && out_o.kind != K_DATA)
      |-> (out_o.valid_bytes == 3'd0 && !out_o.last_word))
    else $error("byte count or last flag set on a non name or data result");

  a_data_ends_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ph_eff == PH_DATA && res_d.last_word) |=> phase_q == PH_TOKEN)
    else $error("last data word did not return to token phase");

endmodule

>>> tb/sv/fdtp_parse_checker.sv
`timescale 1ns / 1ps

module fdtp_parse_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fdtp_pkg::WordBits-1:0] cfg_wdata_i,
  fdtp_in_if                            in_mon,
  fdtp_out_if                           out_mon,
  output int                            mismatches_o,
  output int                            backlog_o
);
  import fdtp_pkg::*;

  phase_e              cur_phase;
  logic [WordBits-1:0] cur_offset;
  logic [WordBits-1:0] bytes_left;
  logic [WordBits-1:0] limit_bytes;
  res_t                results_q[$];
  res_t                want;

  // saturating byte offset
  function automatic void step_offset();
    if (cur_offset > 32'hFFFF_FFFB) begin
      cur_offset = '1;
    end else begin
      cur_offset = cur_offset + WordBytes;
    end
  endfunction

  function automatic res_t classify_word(input logic restart, input logic [WordBits-1:0] word);
    res_t                r;
    logic [WordBits-1:0] take;
    r.kind = K_DONE;
    r.payload = '0;
    r.valid_bytes = '0;
    r.last_word = 1'b0;
    if (restart) begin
      cur_phase = PH_TOKEN;
      cur_offset = '0;
      bytes_left = '0;
    end
    case (cur_phase)
      PH_TOKEN: begin
        if (cur_offset >= limit_bytes) begin
          r.kind = K_ERROR;
          cur_phase = PH_ERROR;
        end else begin
          step_offset();
          case (word)
            TokBeginNode: begin
              r.kind = K_BEGIN;
              cur_phase = PH_NAME;
            end
            TokEndNode: r.kind = K_ENDNODE;
            TokProp: begin
              r.kind = K_PROP;
              cur_phase = PH_LEN;
            end
            TokNop: r.kind = K_NOP;
            TokEnd: begin
              r.kind = K_END;
              cur_phase = PH_DONE;
            end
            default: begin
              r.kind = K_ERROR;
              cur_phase = PH_ERROR;
            end
          endcase
        end
      end
      PH_NAME: begin
        r.kind = K_NAME;
        r.payload = word;
        r.valid_bytes = 3'(WordBytes);
        for (int i = 0; i < WordBytes; i++) begin
          if (!r.last_word && word[WordBits-1-8*i -: 8] == 8'h00) begin
            r.valid_bytes = 3'(i);
            r.last_word = 1'b1;
          end
        end
        if (r.last_word) cur_phase = PH_TOKEN;
        step_offset();
      end
      PH_LEN: begin
        r.kind = K_LEN;
        r.payload = word;
        bytes_left = word;
        cur_phase = PH_NAMEOFF;
        step_offset();
      end
      PH_NAMEOFF: begin
        r.kind = K_NAMEOFF;
        r.payload = word;
        cur_phase = (bytes_left == '0) ? PH_TOKEN : PH_DATA;
        step_offset();
      end
      PH_DATA: begin
        r.kind = K_DATA;
        r.payload = word;
        take = (bytes_left < WordBytes) ? bytes_left : WordBytes;
        r.valid_bytes = take[2:0];
        bytes_left = bytes_left - take;
        if (bytes_left == '0) begin
          r.last_word = 1'b1;
          cur_phase = PH_TOKEN;
        end
        step_offset();
      end
      PH_ERROR: r.kind = K_ERROR;
      default: begin
        r.kind = K_DONE;
        cur_phase = PH_DONE;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_phase = PH_DONE;
      cur_offset = '0;
      bytes_left = '0;
      limit_bytes = SizeLimitReset;
      results_q.delete();
      mismatches_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (results_q.size() == 0) begin
          $error("unexpected result transfer, kind 0x%0h", out_mon.kind);
          mismatches_o++;
        end else begin
          want = results_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_mon.kind));
          check_field("payload", want.payload, out_mon.payload);
          check_field("valid_bytes", 32'(want.valid_bytes), 32'(out_mon.valid_bytes));
          check_field("last_word", 32'(want.last_word), 32'(out_mon.last_word));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        results_q.push_back(classify_word(in_mon.restart, in_mon.word));
      end
      if (cfg_we_i) limit_bytes = cfg_wdata_i;
    end
    backlog_o = results_q.size();
  end

endmodule

>>> tb/sv/fdt_structure_token_parser_tb.sv
`timescale 1ns / 1ps

module fdt_structure_token_parser_tb;
  import fdtp_pkg::*;

  localparam int HoldCycles = 300;
  localparam int PhaseWords = 110;
  localparam int NumPhases = 10;

  typedef struct packed {
    logic                restart;
    logic [WordBits-1:0] word;
  } word_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [WordBits-1:0] cfg_wdata;
  int                  mismatches;
  int                  backlog;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  hold_reqs;
  word_item_t          stim_q[$];

  fdtp_in_if  in_ch ();
  fdtp_out_if out_ch ();

  fdt_structure_token_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  fdtp_parse_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches_o (mismatches),
    .backlog_o    (backlog)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_done != hold_reqs) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic push_word(input logic restart, input logic [WordBits-1:0] word);
    word_item_t it;
    it.restart = restart;
    it.word = word;
    stim_q.push_back(it);
  endtask

  task automatic add_name();
    logic [7:0]          name_bytes[$];
    logic [WordBits-1:0] w;
    int                  n_chars;
    n_chars = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
    for (int i = 0; i < n_chars; i++) name_bytes.push_back(8'($urandom_range(1, 255)));
    name_bytes.push_back(8'h00);
    while (name_bytes.size() % WordBytes != 0) begin
      name_bytes.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(0, 255)));
    end
    while (name_bytes.size() != 0) begin
      for (int i = 0; i < WordBytes; i++) w = {w[WordBits-9:0], name_bytes.pop_front()};
      push_word(1'b0, w);
    end
  endtask

  task automatic add_prop();
    int pick;
    int len;
    pick = $urandom_range(9);
    if (pick == 0) len = 0;
    else if (pick < 8) len = $urandom_range(1, 24);
    else if (pick == 8) len = $urandom_range(25, 80);
    else len = WordBytes * $urandom_range(1, 4);
    push_word(1'b0, TokProp);
    push_word(1'b0, len);
    push_word(1'b0, $urandom());
    for (int i = 0; i < (len + WordBytes - 1) / WordBytes; i++) push_word(1'b0, $urandom());
  endtask

  task automatic add_node(input int depth, input logic first);
    int n_members;
    int pick;
    push_word(first, TokBeginNode);
    add_name();
    n_members = $urandom_range(0, 4);
    for (int k = 0; k < n_members; k++) begin
      pick = $urandom_range(99);
      if (pick < 55) add_prop();
      else if (pick < 70 || depth >= 3) push_word(1'b0, TokNop);
      else add_node(depth + 1, 1'b0);
    end
    push_word(1'b0, TokEndNode);
  endtask

  // well-formed tree, sometimes with a broken word or a restart in the middle
  task automatic add_tree();
    int start;
    int spot;
    start = stim_q.size();
    if ($urandom_range(3) == 0) begin
      push_word(1'b1, TokNop);
      add_node(0, 1'b0);
    end else begin
      add_node(0, 1'b1);
    end
    push_word(1'b0, TokEnd);
    repeat ($urandom_range(0, 2)) push_word(1'b0, $urandom());
    if ($urandom_range(4) == 0) begin
      spot = $urandom_range(start + 1, stim_q.size() - 1);
      case ($urandom_range(2))
        0: stim_q[spot].word = $urandom();
        1: stim_q[spot].word = 32'($urandom_range(0, 15));
        default: stim_q[spot].restart = 1'b1;
      endcase
    end
  endtask

  task automatic add_noise();
    logic [WordBits-1:0] w;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(6))
        0: w = TokBeginNode;
        1: w = TokEndNode;
        2: w = TokProp;
        3: w = TokNop;
        4: w = TokEnd;
        5: w = 32'($urandom_range(0, 15));
        default: w = $urandom();
      endcase
      push_word($urandom_range(3) == 0, w);
    end
  endtask

  task automatic fill_words(input int target);
    while (stim_q.size() < target) begin
      if ($urandom_range(4) == 0) add_noise();
      else add_tree();
    end
  endtask

  task automatic send_words();
    word_item_t it;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      while ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
      in_ch.valid <= 1'b1;
      in_ch.restart <= it.restart;
      in_ch.word <= it.word;
      do @(posedge clk_i); while (!in_ch.ready);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [WordBits-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [WordBits-1:0] limit;
    rst_ni = 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.restart <= 1'b0;
    in_ch.word <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_reqs = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: done after reset, every token, name NUL positions, data tails,
    // zero-length property, unknown token and sticky error, restart that clears the error
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, 32'hFFFF_FFFF);
    push_word(1'b1, TokBeginNode);
    push_word(1'b0, 32'h6162_6300);
    push_word(1'b0, TokProp);
    push_word(1'b0, 32'd5);
    push_word(1'b0, 32'hFFFF_FFFF);
    push_word(1'b0, 32'hFFFF_FFFF);
    push_word(1'b0, 32'h1200_0000);
    push_word(1'b0, TokProp);
    push_word(1'b0, 32'd0);
    push_word(1'b0, 32'd0);
    push_word(1'b0, TokNop);
    push_word(1'b0, TokBeginNode);
    push_word(1'b0, 32'h6162_6364);
    push_word(1'b0, 32'h0000_0000);
    push_word(1'b0, TokEndNode);
    push_word(1'b0, TokEndNode);
    push_word(1'b0, TokEnd);
    push_word(1'b1, 32'hFFFF_FFFF);
    push_word(1'b0, TokBeginNode);
    push_word(1'b1, TokBeginNode);
    push_word(1'b0, 32'h6100_6100);
    push_word(1'b1, TokEnd);
    send_words();

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0, 7: limit = 32'hFFFF_FFFF;
        1: limit = '0;
        2: limit = $urandom_range(4, 200);
        3, 9: limit = SizeLimitReset;
        4: limit = 32'd8;
        5: limit = $urandom();
        6: limit = $urandom_range(40, 600);
        default: limit = $urandom_range(1, 64);
      endcase
      write_limit(limit);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 86;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 86;
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
        end
      endcase
      fill_words(PhaseWords);
      send_words();
    end

    // back-pressure: receiver holds off while the sender keeps offering
    drain();
    write_limit(SizeLimitReset);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_reqs <= hold_reqs + 1;
    fill_words(40);
    send_words();

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
